// ----- rtl/tst_pkg.sv -----
// Shared constants and types of the timeout slot table.
`timescale 1ns / 1ps
package tst_pkg;

  // Default table shape
  localparam int SLOTS_DEF        = 64;
  localparam int OWNER_WIDTH_DEF  = 32;
  localparam int HANDLE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int TAG_W   = 32;
  localparam int TIME_W  = 64;
  localparam int SLEEP_W = 32;

  // Reset tick length and per-tick retire limit
  localparam logic [SLEEP_W-1:0] TICK_RESET = 32'd10000000;
  localparam int MAX_FIRE = 64;
  localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

  // Operation selector on the input tuser
  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

endpackage

// ----- rtl/tst_slot_ram.sv -----
// Slot entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tst_slot_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry, read one entry a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/timeout_slot_table_core.sv -----
// Top level of the timeout slot table: sequencer, active bits and output register.
`timescale 1ns / 1ps
// Each input word is one operation on a table of SLOTS timeout slots, handled by a
// sequencer that walks the slots one per cycle (a tick holds while the output is full)
// through an entry memory with one write and one read port, so only one operation is in
// flight and s_tready is low while it runs. An add stops at the lowest free slot, or at
// the last one when the table is full; delete and tick visit every slot, then a tick
// passes ST_DIFF and ST_CLAMP. Each also waits while the previous result is still
// held on the output. A tick sends one word per retired handle and marks the final one
// with tlast and the sleep time; add, delete and unknown operations send exactly one word.
// The active flags sit in flip-flops cleared at reset, so the table is usable on the first
// cycle after reset; the tick length register may be written whenever the block is idle.
module timeout_slot_table_core
  #(
  parameter int SLOTS        = tst_pkg::SLOTS_DEF,
  parameter int OWNER_WIDTH  = tst_pkg::OWNER_WIDTH_DEF,
  parameter int HANDLE_WIDTH = tst_pkg::HANDLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tick length register
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [191:0] s_tdata,  // owner_tag[31:0], callback_handle[63:32],
                                 // expiry_delay[127:64], now_ns[191:128]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // accepted[0], owner_found[1], fired_handle[33:2],
                                 // sleep_ns[65:34], zero[71:66]
  output logic [0:0]  m_tuser,   // fired[0]
  output logic        m_tlast
);

  import tst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OW = (OWNER_WIDTH < TAG_W) ? OWNER_WIDTH : TAG_W;
  localparam int HW = (HANDLE_WIDTH < TAG_W) ? HANDLE_WIDTH : TAG_W;
  localparam int EW = TIME_W + OW + HW;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEL,
    ST_TICK,
    ST_DIFF,
    ST_CLAMP,
    ST_DONE
  } state_t;

  state_t state;
  logic [SLOTS-1:0] active;
  logic [IW-1:0] idx;
  logic [SLEEP_W-1:0] tick_len;

  // operation operands
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] add_dl;
  logic [OW-1:0] owner_r;
  logic [HW-1:0] handle_r;

  // tick scan state
  logic [FIRE_W-1:0] nfire;
  logic pend_valid;
  logic [HW-1:0] pend_handle;
  logic have;
  logic [TIME_W-1:0] nxt;
  logic [TIME_W-1:0] diff;

  // staged final result
  logic res_acc;
  logic res_found;
  logic res_fired;
  logic [TAG_W-1:0] res_handle;
  logic [SLEEP_W-1:0] res_sleep;

  // output register
  logic out_acc;
  logic out_found;
  logic out_fired;
  logic [TAG_W-1:0] out_handle;
  logic [SLEEP_W-1:0] out_sleep;
  logic out_last;

  // entry memory ports
  logic ram_we;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic [TIME_W-1:0] rd_dl;
  logic [OW-1:0] rd_owner;
  logic [HW-1:0] rd_handle;
  logic out_free;
  logic out_load;
  logic cur_act;
  logic retire;
  logic tick_stall;
  logic [SLEEP_W-1:0] tick_eff;

  tst_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (IW),
    .DW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode the entry read for the current slot and the retire decision
  always_comb begin
    rd_dl      = ram_rdata[TIME_W-1:0];
    rd_owner   = ram_rdata[TIME_W +: OW];
    rd_handle  = ram_rdata[TIME_W+OW +: HW];
    out_free   = !m_tvalid || m_tready;
    cur_act    = active[idx];
    retire     = cur_act && (now_r >= rd_dl) && (nfire < FIRE_W'(MAX_FIRE));
    tick_stall = (state == ST_TICK) && retire && pend_valid && !out_free;
    out_load   = ((state == ST_TICK) && !tick_stall && retire && pend_valid) ||
                 ((state == ST_DONE) && out_free);
    ram_we     = (state == ST_ADD) && !cur_act;
    ram_wdata  = {handle_r, owner_r, add_dl};
    tick_eff   = (tick_len == '0) ? SLEEP_W'(1) : tick_len;
  end

  // Pick the next slot to read: repeat on a stall, wrap after the last slot
  always_comb begin
    if (state == ST_IDLE) begin
      ram_raddr = '0;
    end else if (tick_stall) begin
      ram_raddr = idx;
    end else if (idx == LAST_IDX) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = idx + IW'(1);
    end
  end

  // Tick length register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_len <= TICK_RESET;
    end else if (cfg_wr_en) begin
      tick_len <= cfg_wr_data;
    end
  end

  // Sequencer, slot flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      idx        <= '0;
      nfire      <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // load a new output word, or drop the one taken
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            now_r      <= s_tdata[191:128];
            add_dl     <= s_tdata[191:128] + s_tdata[127:64];
            owner_r    <= s_tdata[OW-1:0];
            handle_r   <= s_tdata[32 +: HW];
            idx        <= '0;
            nfire      <= '0;
            pend_valid <= 1'b0;
            have       <= 1'b0;
            res_acc    <= 1'b0;
            res_found  <= 1'b0;
            res_fired  <= 1'b0;
            res_handle <= '0;
            res_sleep  <= '0;
            unique case (mode_t'(s_tuser))
              MODE_ADD:  state <= ST_ADD;
              MODE_DEL:  state <= ST_DEL;
              MODE_TICK: state <= ST_TICK;
              default:   state <= ST_DONE;
            endcase
          end
        end

        // find the lowest free slot
        ST_ADD: begin
          if (!cur_act) begin
            active[idx] <= 1'b1;
            res_acc     <= 1'b1;
            state       <= ST_DONE;
          end else if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        // clear every slot of the owner
        ST_DEL: begin
          if (cur_act && (rd_owner == owner_r)) begin
            active[idx] <= 1'b0;
            res_found   <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        // retire expired slots, track the earliest remaining deadline
        ST_TICK: begin
          if (!tick_stall) begin
            if (retire) begin
              active[idx] <= 1'b0;
              nfire       <= nfire + FIRE_W'(1);
              pend_valid  <= 1'b1;
              pend_handle <= rd_handle;
              if (pend_valid) begin
                out_acc    <= 1'b0;
                out_found  <= 1'b0;
                out_fired  <= 1'b1;
                out_handle <= TAG_W'(pend_handle);
                out_sleep  <= '0;
                out_last   <= 1'b0;
              end
            end else if (cur_act && (!have || (rd_dl < nxt))) begin
              have <= 1'b1;
              nxt  <= rd_dl;
            end
            if (idx == LAST_IDX) begin
              state <= ST_DIFF;
            end else begin
              idx <= idx + IW'(1);
            end
          end
        end

        // time to the earliest deadline, at least one
        ST_DIFF: begin
          diff  <= (nxt > now_r) ? (nxt - now_r) : TIME_W'(1);
          state <= ST_CLAMP;
        end

        // clamp to the tick length and stage the final word
        ST_CLAMP: begin
          if (!have || (diff > TIME_W'(tick_eff))) begin
            res_sleep <= tick_eff;
          end else begin
            res_sleep <= diff[SLEEP_W-1:0];
          end
          res_fired  <= pend_valid;
          res_handle <= pend_valid ? TAG_W'(pend_handle) : '0;
          state      <= ST_DONE;
        end

        // hand the final word to the output register
        ST_DONE: begin
          if (out_free) begin
            out_acc    <= res_acc;
            out_found  <= res_found;
            out_fired  <= res_fired;
            out_handle <= res_handle;
            out_sleep  <= res_sleep;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {6'd0, out_sleep, out_handle, out_found, out_acc};
  assign m_tuser  = out_fired;
  assign m_tlast  = out_last;

  // No held handle may survive into the idle state
  a_idle_no_pend : assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("held fired handle left over in idle");

  // Only tick words come without tlast, and they always report a handle
  a_mid_fired : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[0] && (m_tdata[65:34] == '0)))
    else $error("non-final result word without fired handle");

  // Retire count stays within the per-tick limit
  a_fire_limit : assert property (@(posedge clk) disable iff (rst)
    nfire <= FIRE_W'(MAX_FIRE))
    else $error("retire count beyond limit");

  // A stall on a retire holds the slot index
  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    tick_stall |=> ((state == ST_TICK) && $stable(idx)))
    else $error("slot index moved during output stall");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the timeout slot table core.
module testbench;
  import tst_pkg::*;

  localparam int          SLOTS        = SLOTS_DEF;
  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int          RANDOM_CMDS  = 420;
  localparam logic [1:0]  MODE_BAD     = 2'd3;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  // One operation on the table
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] owner;
    logic [31:0] handle;
    logic [63:0] delay;
    logic [63:0] now;
  } timer_cmd_t;

  // One result word
  typedef struct packed {
    logic        accepted;
    logic        owner_found;
    logic        fired;
    logic [31:0] handle;
    logic [31:0] sleep;
    logic        last;
  } timer_report_t;

  // Directed row: command plus an optional hand-written result
  typedef struct packed {
    timer_cmd_t    cmd;
    logic          typed;
    timer_report_t report;
  } stim_row_t;

  // Hand-written results: accepted, owner_found, fired, handle, sleep, last
  localparam timer_report_t LONE_LAST      = {3'b000, 32'd0, 32'd0, 1'b1};
  localparam timer_report_t ADD_TAKEN      = {3'b100, 32'd0, 32'd0, 1'b1};
  localparam timer_report_t SLEEP_AT_RESET = {3'b000, 32'd0, TICK_RESET, 1'b1};

  logic         clk         = 1'b0;
  logic         rst         = 1'b1;
  logic         cfg_wr_en   = 1'b0;
  logic [31:0]  cfg_wr_data = '0;
  logic         s_tvalid    = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata     = '0;
  logic [1:0]   s_tuser     = '0;
  logic         m_tvalid;
  logic         m_tready    = 1'b0;
  logic [71:0]  m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  // Predicted table contents and tick length
  logic          slot_busy [SLOTS];
  logic [63:0]   slot_due  [SLOTS];
  logic [31:0]   slot_tag  [SLOTS];
  logic [31:0]   slot_cb   [SLOTS];
  logic [31:0]   tick_len;

  timer_report_t pending_reports [$];
  stim_row_t     dir_rows [$];
  logic [31:0]   owner_pool [8];
  int            fail_count  = 0;
  int            cmds_sent   = 0;
  int            cycle_count = 0;
  bit            no_idle     = 1'b0;

  always #2 clk = ~clk;

  timeout_slot_table_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  function automatic timer_cmd_t make_cmd(input logic [1:0] mode, input logic [31:0] owner,
                                          input logic [31:0] handle, input logic [63:0] delay,
                                          input logic [63:0] now);
    timer_cmd_t cmd;
    cmd.mode   = mode;
    cmd.owner  = owner;
    cmd.handle = handle;
    cmd.delay  = delay;
    cmd.now    = now;
    return cmd;
  endfunction

  function automatic stim_row_t stim_row(input timer_cmd_t cmd, input logic typed,
                                         input timer_report_t report);
    stim_row_t row;
    row.cmd    = cmd;
    row.typed  = typed;
    row.report = report;
    return row;
  endfunction

  // Mostly owners from a small pool so deletes hit, sometimes any tag
  function automatic logic [31:0] pick_owner();
    if ($urandom_range(3) == 0) begin
      return $urandom;
    end
    return owner_pool[$urandom_range(7)];
  endfunction

  // Apply one command to the predicted table and queue the words it yields
  task automatic timer_table_step(input timer_cmd_t cmd);
    timer_report_t rpt;
    timer_report_t held;
    logic          have_held;
    logic          placed;
    logic          have_next;
    logic [63:0]   next_due;
    logic [63:0]   gap;
    logic [31:0]   tick;
    int            fired_cnt;
    rpt       = '0;
    rpt.last  = 1'b1;
    held      = '0;
    have_held = 1'b0;
    placed    = 1'b0;
    have_next = 1'b0;
    next_due  = '0;
    fired_cnt = 0;
    tick      = (tick_len == 32'd0) ? 32'd1 : tick_len;
    case (cmd.mode)
      MODE_ADD: begin
        // take the lowest free slot
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !slot_busy[i]) begin
            slot_busy[i] = 1'b1;
            slot_tag[i]  = cmd.owner;
            slot_cb[i]   = cmd.handle;
            slot_due[i]  = cmd.now + cmd.delay;
            placed       = 1'b1;
          end
        end
        rpt.accepted = placed;
        pending_reports.push_back(rpt);
      end
      MODE_DEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_tag[i] == cmd.owner) begin
            slot_busy[i]    = 1'b0;
            rpt.owner_found = 1'b1;
          end
        end
        pending_reports.push_back(rpt);
      end
      MODE_TICK: begin
        // retire expired slots, lowest index first; hold back the newest word
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && cmd.now >= slot_due[i] && fired_cnt < MAX_FIRE) begin
            slot_busy[i] = 1'b0;
            if (have_held) begin
              pending_reports.push_back(held);
            end
            held        = '0;
            held.fired  = 1'b1;
            held.handle = slot_cb[i];
            have_held   = 1'b1;
            fired_cnt++;
          end
        end
        // earliest remaining deadline sets the sleep time
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && (!have_next || slot_due[i] < next_due)) begin
            next_due  = slot_due[i];
            have_next = 1'b1;
          end
        end
        if (have_next) begin
          gap       = (next_due > cmd.now) ? next_due - cmd.now : 64'd1;
          rpt.sleep = (gap > tick) ? tick : gap[31:0];
        end else begin
          rpt.sleep = tick;
        end
        if (have_held) begin
          held.sleep = rpt.sleep;
          held.last  = 1'b1;
          rpt        = held;
        end
        pending_reports.push_back(rpt);
      end
      default: begin
        pending_reports.push_back(rpt);
      end
    endcase
  endtask

  // Drive one word, wait for the handshake, then predict
  task automatic send_cmd(input timer_cmd_t cmd);
    while (!no_idle && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd.mode;
    s_tdata  <= {cmd.now, cmd.delay, cmd.handle, cmd.owner};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    timer_table_step(cmd);
    cmds_sent++;
  endtask

  // Write the tick length once every expected word is out
  task automatic write_tick_len(input logic [31:0] len);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_len = len;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Sink result words and compare against the oldest prediction
  always @(posedge clk) begin : sink_reports
    timer_report_t want;
    if (m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(m_tdata[0]));
        check_field("owner_found", 32'(want.owner_found), 32'(m_tdata[1]));
        check_field("fired", 32'(want.fired), 32'(m_tuser[0]));
        check_field("fired_handle", want.handle, m_tdata[33:2]);
        check_field("sleep_ns", want.sleep, m_tdata[65:34]);
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
    m_tready <= !rst && (no_idle || $urandom_range(99) >= 25);
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    timer_cmd_t  cmd;
    logic [63:0] base;
    logic [63:0] t_now;
    int          pick;
    tick_len = TICK_RESET;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    foreach (owner_pool[i]) owner_pool[i] = $urandom;
    owner_pool[0] = 32'h0000_0000;
    owner_pool[1] = 32'hFFFF_FFFF;

    // Directed: empty table, unknown op, field extremes, wrap, clamp, minimum sleep
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 0), 1'b1, SLEEP_AT_RESET));
    dir_rows.push_back(stim_row(make_cmd(MODE_DEL, 0, 0, 0, 0), 1'b1, LONE_LAST));
    dir_rows.push_back(stim_row(make_cmd(MODE_BAD, '1, '1, ALL_ONES, ALL_ONES), 1'b1,
                                LONE_LAST));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, '1, '1, ALL_ONES, 0), 1'b1, ADD_TAKEN));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 0, 0, 0, ALL_ONES), 1'b1, ADD_TAKEN));
    // deadline wraps around to 1
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 1, 32'hA5A5_A5A5, 2, ALL_ONES), 1'b1,
                                ADD_TAKEN));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 0), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 1), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 1, 32'h5A5A_5A5A, 20000000, 1), 1'b0, '0));
    // far deadline: sleep clamps to the tick length
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 5000), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_DEL, 1, 0, 0, 0), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_DEL, 1, 0, 0, 0), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 32'h1234_5678, 1, 3, 100), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 32'h1234_5678, 2, 3, 100), 1'b0, '0));
    // one tick short of the deadline, then two fire together
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 102), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, 103), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_ADD, 7, 32'h77, ALL_ONES, ALL_ONES), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, ALL_ONES - 2), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, ALL_ONES), 1'b0, '0));
    dir_rows.push_back(stim_row(make_cmd(MODE_TICK, 0, 0, 0, ALL_ONES), 1'b1, SLEEP_AT_RESET));
    dir_rows.push_back(stim_row(make_cmd(MODE_DEL, '1, 0, 0, 0), 1'b1, LONE_LAST));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_cmd(dir_rows[k].cmd);
      if (dir_rows[k].typed) begin
        void'(pending_reports.pop_back());
        pending_reports.push_back(dir_rows[k].report);
      end
    end

    // Fill the table, overflow it, free some, then retire a full load in one tick
    write_tick_len(32'd0);
    no_idle = 1'b1;
    base = {$urandom, $urandom} >> 1;
    for (int n = 0; n < SLOTS + 2; n++) begin
      send_cmd(make_cmd(MODE_ADD, pick_owner(), $urandom, 64'($urandom_range(1, 1000)), base));
    end
    send_cmd(make_cmd(MODE_DEL, owner_pool[2], $urandom, {$urandom, $urandom}, base));
    send_cmd(make_cmd(MODE_ADD, owner_pool[2], $urandom, 64'd1, base));
    send_cmd(make_cmd(MODE_TICK, $urandom, $urandom, {$urandom, $urandom}, base + 64'd5000));
    send_cmd(make_cmd(MODE_TICK, $urandom, $urandom, {$urandom, $urandom}, base + 64'd5001));
    no_idle = 1'b0;

    // Random phases, each under its own tick length
    t_now = base + 64'd10000;
    for (int phase = 0; cmds_sent < RANDOM_CMDS; phase++) begin
      case (phase % 6)
        0: write_tick_len(32'hFFFF_FFFF);
        1: write_tick_len(32'd1);
        2: write_tick_len($urandom_range(1, 400));
        3: write_tick_len(TICK_RESET);
        4: write_tick_len($urandom);
        default: write_tick_len(32'd0);
      endcase
      no_idle = (phase == 1);
      if ($urandom_range(3) == 0) begin
        t_now = {$urandom, $urandom};
      end
      repeat (40) begin
        t_now = t_now + 64'($urandom_range(0, 300));
        pick  = $urandom_range(99);
        if (pick < 45) begin
          cmd = make_cmd(MODE_ADD, pick_owner(), $urandom,
                         ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                  : 64'($urandom_range(0, 2000)),
                         t_now);
        end else if (pick < 60) begin
          cmd = make_cmd(MODE_DEL, pick_owner(), $urandom, {$urandom, $urandom}, t_now);
        end else if (pick < 90) begin
          cmd = make_cmd(MODE_TICK, $urandom, $urandom, {$urandom, $urandom}, t_now);
        end else if (pick < 95) begin
          cmd = make_cmd(MODE_BAD, $urandom, $urandom, {$urandom, $urandom}, t_now);
        end else begin
          // noise: any op with arbitrary times
          cmd = make_cmd(2'($urandom_range(3)), $urandom, $urandom, {$urandom, $urandom},
                         {$urandom, $urandom});
        end
        send_cmd(cmd);
      end
    end

    // Drain and report
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tst_pkg.sv
rtl/tst_slot_ram.sv
rtl/timeout_slot_table_core.sv
bench/testbench.sv
